// File: design/ole_pkg.sv
// Package for the ordered list engine: request and response payload types,
// opcode, status and cell command codes. No dependencies.

package ole_pkg;

   localparam int CAPACITY = 64;

   localparam int OPCODE_W = 4;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 3;
   localparam int OPOS_W   = 6;
   localparam int COUNT_W  = 7;

   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_INSERT_AT  = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_BEFORE     = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_AFTER      = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_FIND       = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_READ       = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_DELETE_AT  = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_DELETE_VAL = 4'd8;
   localparam logic [OPCODE_W-1:0] OP_CLEAR      = 4'd9;

   localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOPOS  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NOMARK = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd4;

   // cell commands, broadcast to every cell of the chain
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_ROTATE = 2'd1;
   localparam logic [1:0] CELL_INSERT = 2'd2;
   localparam logic [1:0] CELL_DELETE = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic signed [VALUE_W-1:0] item_value;
      logic signed [VALUE_W-1:0] mark_value;
      logic [POS_W-1:0]          position;
   } ole_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] out_value;
      logic [OPOS_W-1:0]         out_position;
      logic [COUNT_W-1:0]        out_count;
   } ole_rsp_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [VALUE_W-1:0] data;
   } ole_cell_ctl_type;

endpackage

// File: design/ole_cell.sv
// One storage cell of the list chain: holds one entry and takes its
// neighbor's value on rotate, insert or delete. Depends on ole_pkg.

module ole_cell #(
   parameter int IW    = 6,
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  ole_pkg::ole_cell_ctl_type ctl,
   input  logic [IW-1:0]             idx,
   input  logic [31:0]               left_value,
   input  logic [31:0]               right_value,
   output logic [31:0]               value
);
   import ole_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic [VALUE_W-1:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.cmd)
         CELL_HOLD: begin
            value_in = value_ff;
         end
         CELL_ROTATE: begin
            value_in = right_value;
         end
         CELL_INSERT: begin
            if (MY_IDX > idx) begin
               value_in = left_value;
            end else if (MY_IDX == idx) begin
               value_in = ctl.data;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= idx) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: design/ole_chain.sv
// Row of list cells wired to their neighbors; the last cell wraps to the
// first so the row can rotate. Depends on ole_pkg and ole_cell.

module ole_chain #(
   parameter int CAPACITY = 64,
   parameter int IW       = 6
) (
   input  logic                      clock,
   input  ole_pkg::ole_cell_ctl_type ctl,
   input  logic [IW-1:0]             idx,
   output logic [31:0]               head_value
);
   import ole_pkg::*;

   logic [VALUE_W-1:0] cell_value [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid
         assign left_v = cell_value[i-1];
      end
      // wrap the last cell to the head for rotation
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[0];
      end else begin : g_inner
         assign right_v = cell_value[i+1];
      end

      ole_cell #(
         .IW    (IW),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .idx         (idx),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[i])
      );
   end

   assign head_value = cell_value[0];

endmodule

// File: design/ordered_list_engine.sv
// Top level of the ordered list engine: request decode, scan sequencer and
// response register around the cell chain. Depends on ole_pkg, ole_chain.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  ole_pkg::ole_req_type
//   rsp_      out        rsp_valid / rsp_stall  ole_pkg::ole_rsp_type
//
// Push back, push front, insert at, clear and unused opcodes go from the
// transfer straight to execute. Insert before/after, find, read, delete at
// and delete by value first rotate the chain one full turn past the head
// cell, which does the compare and capture, then execute.
// Reset clears the count, the sequencer and the response valid; cell
// contents stay undefined, only positions below the count are ever shown.
// A stalled response holds in its register; the next request transfers
// while it waits, and execute waits only for the register to free.

module ordered_list_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ole_pkg::ole_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ole_pkg::ole_rsp_type rsp_data
);
   import ole_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic                found_ff, found_in;
   logic [IW-1:0]       mpos_ff, mpos_in;
   logic [VALUE_W-1:0]  capt_ff, capt_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [VALUE_W-1:0]  item_ff, item_in;
   logic [VALUE_W-1:0]  mark_ff, mark_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ole_rsp_type         rsp_ff, rsp_in;

   ole_cell_ctl_type    cell_ctl;
   logic [IW-1:0]       cell_idx;
   logic [VALUE_W-1:0]  head_value;

   logic                req_fire, exec_fire, needs_scan, full, empty;
   logic [XW-1:0]       pos_x, count_x, scan_x;
   logic [VALUE_W-1:0]  key;
   logic [STATUS_W-1:0] ex_status;
   logic [VALUE_W-1:0]  ex_value;
   logic [IW-1:0]       ex_opos;

   function automatic logic [OPOS_W-1:0] mpos_sel(input logic [IW-1:0] p);
      logic [XW-1:0] px;
      px = XW'(p);
      return px[OPOS_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] count_x_next(input logic [CW-1:0] c);
      logic [XW-1:0] cx;
      cx = XW'(c);
      return cx[COUNT_W-1:0];
   endfunction

   ole_chain #(
      .CAPACITY (CAPACITY),
      .IW       (IW)
   ) u_chain (
      .clock      (clock),
      .ctl        (cell_ctl),
      .idx        (cell_idx),
      .head_value (head_value)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign pos_x   = XW'(pos_ff);
   assign count_x = XW'(count_ff);
   assign scan_x  = XW'(scan_ff);
   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign key     = (op_ff == OP_FIND) ? item_ff : mark_ff;

   always_comb begin
      case (req_data.opcode)
         OP_BEFORE, OP_AFTER, OP_FIND, OP_READ, OP_DELETE_AT, OP_DELETE_VAL: begin
            needs_scan = 1'b1;
         end
         default: begin
            needs_scan = 1'b0;
         end
      endcase
   end

   // Decide the outcome of the held request and the chain update for it.
   always_comb begin
      ex_status     = STAT_OK;
      ex_value      = '0;
      ex_opos       = '0;
      cell_ctl.cmd  = CELL_HOLD;
      cell_ctl.data = item_ff;
      cell_idx      = '0;
      count_in      = count_ff;
      case (op_ff)
         OP_PUSH_BACK: begin
            if (full) begin
               ex_status = STAT_FULL;
            end else begin
               cell_ctl.cmd = CELL_INSERT;
               cell_idx     = count_ff[IW-1:0];
               count_in     = count_ff + 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               ex_status = STAT_FULL;
            end else begin
               cell_ctl.cmd = CELL_INSERT;
               count_in     = count_ff + 1'b1;
            end
         end
         OP_INSERT_AT: begin
            if (full) begin
               ex_status = STAT_FULL;
            end else if (pos_x > count_x) begin
               ex_status = STAT_NOPOS;
            end else begin
               cell_ctl.cmd = CELL_INSERT;
               cell_idx     = pos_x[IW-1:0];
               count_in     = count_ff + 1'b1;
            end
         end
         OP_BEFORE: begin
            if (empty) begin
               ex_status = STAT_EMPTY;
            end else if (!found_ff) begin
               ex_status = STAT_NOMARK;
            end else if (full) begin
               ex_status = STAT_FULL;
            end else begin
               cell_ctl.cmd = CELL_INSERT;
               cell_idx     = mpos_ff;
               count_in     = count_ff + 1'b1;
            end
         end
         OP_AFTER: begin
            if (!found_ff) begin
               ex_status = STAT_NOMARK;
            end else if (full) begin
               ex_status = STAT_FULL;
            end else begin
               cell_ctl.cmd = CELL_INSERT;
               cell_idx     = mpos_ff + 1'b1;
               count_in     = count_ff + 1'b1;
            end
         end
         OP_FIND: begin
            if (!found_ff) begin
               ex_status = STAT_NOMARK;
            end else begin
               ex_opos = mpos_ff;
            end
         end
         OP_READ: begin
            if (pos_x >= count_x) begin
               ex_status = STAT_NOPOS;
            end else begin
               ex_value = capt_ff;
            end
         end
         OP_DELETE_AT: begin
            if (empty) begin
               ex_status = STAT_EMPTY;
            end else if (pos_x >= count_x) begin
               ex_status = STAT_NOPOS;
            end else begin
               ex_value     = capt_ff;
               cell_ctl.cmd = CELL_DELETE;
               cell_idx     = pos_x[IW-1:0];
               count_in     = count_ff - 1'b1;
            end
         end
         OP_DELETE_VAL: begin
            if (empty) begin
               ex_status = STAT_EMPTY;
            end else if (!found_ff) begin
               ex_status = STAT_NOMARK;
            end else begin
               ex_opos      = mpos_ff;
               ex_value     = mark_ff;
               cell_ctl.cmd = CELL_DELETE;
               cell_idx     = mpos_ff;
               count_in     = count_ff - 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            ex_status = STAT_OK;
         end
      endcase

      // rotate on scan; else update chain and count only on response load
      if (state_ff == ST_SCAN) begin
         cell_ctl.cmd = CELL_ROTATE;
         count_in     = count_ff;
      end else if (!exec_fire) begin
         cell_ctl.cmd = CELL_HOLD;
         count_in     = count_ff;
      end
   end

   // Sequencer: transfer, optional full rotation of the chain, execute.
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      found_in = found_ff;
      mpos_in  = mpos_ff;
      capt_in  = capt_ff;
      op_in    = op_ff;
      item_in  = item_ff;
      mark_in  = mark_ff;
      pos_in   = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_data.opcode;
               item_in  = req_data.item_value;
               mark_in  = req_data.mark_value;
               pos_in   = req_data.position;
               scan_in  = '0;
               found_in = 1'b0;
               state_in = needs_scan ? ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            // head cell holds list position scan_ff this cycle
            if (!found_ff && (scan_x < count_x) && (head_value == key)) begin
               found_in = 1'b1;
               mpos_in  = scan_ff;
            end
            if (scan_x == pos_x) begin
               capt_in = head_value;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == LAST_IDX) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: load on execute, drop once transferred.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (exec_fire) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = ex_status;
         rsp_in.out_value    = ex_value;
         rsp_in.out_position = mpos_sel(ex_opos);
         rsp_in.out_count    = count_x_next(count_in);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      found_ff <= found_in;
      mpos_ff  <= mpos_in;
      capt_ff  <= capt_in;
      op_ff    <= op_in;
      item_ff  <= item_in;
      mark_ff  <= mark_in;
      pos_ff   <= pos_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: tb/tb_ordered_list_engine.sv
// Self-checking testbench for ordered_list_engine: directed table, then random
// operation mix and list-fill sequences, scored against a built-in list model
// or typed-in responses. Depends on ole_pkg and the ordered_list_engine RTL.
`timescale 1ns / 100ps

module tb_ordered_list_engine;

   import ole_pkg::*;

   localparam int CLK_HALF         = 5;
   localparam int RESET_CYCLES     = 9;
   localparam int TOTAL_ITEMS      = 650;
   localparam int QUIET_TAIL       = 100;
   localparam int HOLD_AT          = 220;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TIMEOUT_NS       = 5_000_000;

   // highest opcode value; nothing is assigned to it
   localparam logic [OPCODE_W-1:0] OP_SPARE_MAX = OPCODE_W'((1 << OPCODE_W) - 1);

   localparam logic [OPCODE_W-1:0] INSERT_OPS [5] =
      '{OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AT, OP_BEFORE, OP_AFTER};

   typedef struct {
      ole_req_type req;
      bit          fixed;   // use the typed-in response instead of the model
      ole_rsp_type rsp;
   } directed_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ole_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ole_rsp_type rsp_data;

   // list model: entries kept densely in positions 0..list_len-1
   logic [VALUE_W-1:0] list_mem [CAPACITY];
   int unsigned        list_len = 0;

   ole_rsp_type      pending_rsp_q [$];
   directed_row_type directed_rows [$];

   int unsigned idle_rate      = 0;   // 0: no idling, else idle with chance 1 in idle_rate+1
   int unsigned items_sent     = 0;
   int unsigned rsp_checked    = 0;
   int unsigned fail_count     = 0;
   int unsigned full_answers   = 0;
   int unsigned empty_answers  = 0;
   int unsigned miss_answers   = 0;
   bit          long_hold_done = 1'b0;

   ordered_list_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------
   // List model
   // ---------------------------------------------------------------------

   // Open a gap at p (p <= list_len < CAPACITY) and store v there.
   function automatic void list_insert(input int unsigned p, input logic [VALUE_W-1:0] v);
      for (int unsigned i = list_len; i > p; i--)
         list_mem[i] = list_mem[i-1];
      list_mem[p] = v;
      list_len++;
   endfunction

   // Close the gap at p (p < list_len) and hand back what was there.
   function automatic logic [VALUE_W-1:0] list_remove(input int unsigned p);
      logic [VALUE_W-1:0] v;
      v = list_mem[p];
      for (int unsigned i = p; i + 1 < list_len; i++)
         list_mem[i] = list_mem[i+1];
      list_len--;
      return v;
   endfunction

   // First position holding v, or list_len on a miss.
   function automatic int unsigned list_search(input logic [VALUE_W-1:0] v);
      for (int unsigned i = 0; i < list_len; i++)
         if (list_mem[i] == v)
            return i;
      return list_len;
   endfunction

   // Apply one operation to the model and return the response it must give.
   function automatic ole_rsp_type apply_list_op(input ole_req_type r);
      ole_rsp_type res;
      int unsigned hit;
      bit          full;
      res  = '0;
      full = (list_len >= CAPACITY);
      // every search runs on the list as it stood before the operation
      hit  = list_search(r.opcode == OP_FIND ? r.item_value : r.mark_value);
      case (r.opcode)
         OP_PUSH_BACK: begin
            if (full) res.status = STAT_FULL;
            else list_insert(list_len, r.item_value);
         end
         OP_PUSH_FRONT: begin
            if (full) res.status = STAT_FULL;
            else list_insert(0, r.item_value);
         end
         OP_INSERT_AT: begin
            if (full) res.status = STAT_FULL;
            else if (r.position > list_len) res.status = STAT_NOPOS;
            else list_insert(r.position, r.item_value);
         end
         OP_BEFORE: begin
            if (list_len == 0) res.status = STAT_EMPTY;
            else if (hit >= list_len) res.status = STAT_NOMARK;
            else if (full) res.status = STAT_FULL;
            else list_insert(hit, r.item_value);
         end
         OP_AFTER: begin
            if (hit >= list_len) res.status = STAT_NOMARK;
            else if (full) res.status = STAT_FULL;
            else list_insert(hit + 1, r.item_value);
         end
         OP_FIND: begin
            if (hit >= list_len) res.status = STAT_NOMARK;
            else res.out_position = OPOS_W'(hit);
         end
         OP_READ: begin
            if (r.position >= list_len) res.status = STAT_NOPOS;
            else res.out_value = list_mem[r.position];
         end
         OP_DELETE_AT: begin
            if (list_len == 0) res.status = STAT_EMPTY;
            else if (r.position >= list_len) res.status = STAT_NOPOS;
            else res.out_value = list_remove(r.position);
         end
         OP_DELETE_VAL: begin
            if (list_len == 0) res.status = STAT_EMPTY;
            else if (hit >= list_len) res.status = STAT_NOMARK;
            else begin
               res.out_position = OPOS_W'(hit);
               res.out_value    = list_remove(hit);
            end
         end
         OP_CLEAR: list_len = 0;
         default: ;
      endcase
      res.out_count = COUNT_W'(list_len);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic directed_row_type dir_row(
      input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] item,
      input logic [VALUE_W-1:0] mark, input logic [POS_W-1:0] pos, input bit fixed,
      input logic [STATUS_W-1:0] st, input logic [VALUE_W-1:0] val,
      input logic [OPOS_W-1:0] opos, input logic [COUNT_W-1:0] cnt);
      directed_row_type row;
      row.req   = '{opcode: op, item_value: item, mark_value: mark, position: pos};
      row.fixed = fixed;
      row.rsp   = '{status: st, out_value: val, out_position: opos, out_count: cnt};
      return row;
   endfunction

   // Mix of values: entries already stored (to hit marks and keys), a small
   // pool that breeds duplicates, the signed extremes, and anything at all.
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] edges [4];
      edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
      case ($urandom_range(0, 5))
         0, 1: begin
            if (list_len != 0) return list_mem[$urandom_range(0, list_len - 1)];
            return $urandom;
         end
         2: return VALUE_W'($urandom_range(0, 7));
         3: return edges[$urandom_range(0, 3)];
         default: return $urandom;
      endcase
   endfunction

   function automatic ole_req_type draw_request();
      ole_req_type r;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4)
         r.opcode = OPCODE_W'($urandom_range(int'(OP_CLEAR) + 1, int'(OP_SPARE_MAX)));
      else if (roll < 6)
         r.opcode = OP_CLEAR;
      else
         r.opcode = OPCODE_W'($urandom_range(int'(OP_PUSH_BACK), int'(OP_DELETE_VAL)));
      r.item_value = pick_value();
      r.mark_value = pick_value();
      // mostly in range (including one past the end), sometimes anywhere
      if ($urandom_range(0, 9) < 7) r.position = POS_W'($urandom_range(0, list_len));
      else r.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
      return r;
   endfunction

   // Offer one request, hold it until it transfers, then book its response.
   // Runs right after a rising edge; leaves right after the transfer edge.
   task automatic send_request(input ole_req_type r, input bit fixed,
                               input ole_rsp_type typed_rsp);
      ole_rsp_type modeled;
      int unsigned gap;
      if (idle_rate != 0 && $urandom_range(0, idle_rate) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      modeled = apply_list_op(r);
      pending_rsp_q.push_back(fixed ? typed_rsp : modeled);
      items_sent++;
   endtask

   // Grow the list to capacity with random inserts, then try every insert
   // kind against the full list. Marks are taken from the list so that
   // insert before/after get past the search and hit the full check.
   task automatic fill_list();
      ole_req_type r;
      while (list_len < CAPACITY) begin
         r.opcode     = INSERT_OPS[$urandom_range(0, 2)];
         r.item_value = pick_value();
         r.mark_value = $urandom;
         r.position   = POS_W'($urandom_range(0, list_len));
         send_request(r, 1'b0, '0);
      end
      foreach (INSERT_OPS[k]) begin
         r.opcode     = INSERT_OPS[k];
         r.item_value = $urandom;
         r.mark_value = list_mem[$urandom_range(0, CAPACITY - 1)];
         r.position   = POS_W'($urandom_range(0, CAPACITY));
         send_request(r, 1'b0, '0);
      end
   endtask

   initial begin : request_side
      int unsigned fills_done;
      fills_done = 0;

      // Directed table. Typed-in responses only where they are obvious.
      //                          op             item          mark          pos   fix
      directed_rows.push_back(dir_row(OP_READ,       0,            0,            0,   1,
                                      STAT_NOPOS,  0, 0, 0));
      directed_rows.push_back(dir_row(OP_DELETE_AT,  0,            0,            0,   1,
                                      STAT_EMPTY,  0, 0, 0));
      directed_rows.push_back(dir_row(OP_DELETE_VAL, 0,            5,            0,   1,
                                      STAT_EMPTY,  0, 0, 0));
      directed_rows.push_back(dir_row(OP_BEFORE,     1,            5,            0,   1,
                                      STAT_EMPTY,  0, 0, 0));
      directed_rows.push_back(dir_row(OP_AFTER,      1,            5,            0,   1,
                                      STAT_NOMARK, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_FIND,       5,            0,            0,   1,
                                      STAT_NOMARK, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_INSERT_AT,  1,            0,            1,   1,
                                      STAT_NOPOS,  0, 0, 0));
      directed_rows.push_back(dir_row(OP_INSERT_AT,  32'h7FFF_FFFF, 0,           0,   1,
                                      STAT_OK,     0, 0, 1));
      directed_rows.push_back(dir_row(OP_PUSH_BACK,  32'h8000_0000, 0,           0,   1,
                                      STAT_OK,     0, 0, 2));
      directed_rows.push_back(dir_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 0,           0,   1,
                                      STAT_OK,     0, 0, 3));
      directed_rows.push_back(dir_row(OP_INSERT_AT,  0,            0,            3,   1,
                                      STAT_OK,     0, 0, 4));
      directed_rows.push_back(dir_row(OP_INSERT_AT,  5,            0,            64,  1,
                                      STAT_NOPOS,  0, 0, 4));
      // from here on the model scores the rows, but for the final clear
      directed_rows.push_back(dir_row(OP_BEFORE,     32'h1234_5678, 32'h8000_0000, 0, 0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_AFTER,      32'h55AA_55AA, 32'hFFFF_FFFF, 0, 0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_AFTER,      7,            0,            0,   0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_BEFORE,     1,            99,           0,   0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_FIND,       32'h8000_0000, 0,           0,   0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_READ,       0,            0,            0,   0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_READ,       0,            0,            127, 0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_DELETE_AT,  0,            0,            7,   0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_DELETE_AT,  0,            0,            0,   0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_DELETE_VAL, 0,            32'h7FFF_FFFF, 0,  0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_DELETE_VAL, 0,            42,           0,   0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_SPARE_MAX,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 127, 0,
                                      0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_CLEAR,      0,            0,            0,   1,
                                      STAT_OK,     0, 0, 0));

      // hold reset, release it at an edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      idle_rate = 3;
      foreach (directed_rows[k])
         send_request(directed_rows[k].req, directed_rows[k].fixed, directed_rows[k].rsp);

      // Random part. Idling rate moves around; every third window of 80
      // transfers runs with no idling, and the tail runs with none at all.
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= TOTAL_ITEMS - QUIET_TAIL || (items_sent / 80) % 3 == 2)
            idle_rate = 0;
         else
            idle_rate = 2 + (items_sent / 80) % 5;
         if (fills_done < 2 && items_sent >= 150 + 250 * fills_done) begin
            fills_done++;
            fill_list();
         end else begin
            send_request(draw_request(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain, then give the block a full scan time to show anything extra
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("summary: %0d requests, %0d responses checked", items_sent, rsp_checked);
      $display("summary: %0d full, %0d empty, %0d not-found answers; %0d mismatches",
               full_answers, empty_answers, miss_answers, fail_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random stall bursts, plus one long hold-off so that
   // the response register fills and the block pushes back on requests.
   // ---------------------------------------------------------------------
   initial begin : response_side
      int unsigned burst;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!long_hold_done && items_sent >= HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_rate != 0 && $urandom_range(0, idle_rate) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Scoreboard: every response transfer against the oldest booked one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      ole_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.out_value !== want.out_value) begin
               $error("out_value: expected %0d, got %0d", want.out_value, rsp_data.out_value);
               fail_count++;
            end
            if (rsp_data.out_position !== want.out_position) begin
               $error("out_position: expected %0d, got %0d",
                      want.out_position, rsp_data.out_position);
               fail_count++;
            end
            if (rsp_data.out_count !== want.out_count) begin
               $error("out_count: expected %0d, got %0d", want.out_count, rsp_data.out_count);
               fail_count++;
            end
            rsp_checked++;
            if (want.status == STAT_FULL) full_answers++;
            if (want.status == STAT_EMPTY) empty_answers++;
            if (want.status == STAT_NOMARK) miss_answers++;
         end
      end
   end

   // watchdog
   initial begin : run_limit
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
